[hdl/gli_pkg.sv]
// Shared constants, types and the segment boundary function for the gamma
// table interpolator. No dependencies.
package gli_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int SEGMENT_COUNT = 32;
  localparam int SAMPLE_WIDTH  = 12;

  localparam int Q_BITS = 16;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int XW     = IDX_W + 1;
  localparam int CNT_W  = $clog2(SEGMENT_COUNT + 1);
  localparam int PROD_W = Q_BITS + XW;
  localparam int DIV_CW = $clog2(SAMPLE_WIDTH + 1);
  localparam int unsigned STEP = ((TABLE_ENTRIES - 1) << Q_BITS) / SEGMENT_COUNT;

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [IDX_W-1:0]        index_t;

  // First table entry of segment k, from the Q16 step.
  function automatic logic [XW-1:0] seg_start(input logic [CNT_W-1:0] k);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(STEP) * PROD_W'(k);
    return prod[Q_BITS +: XW];
  endfunction

endpackage

[hdl/gli_point_if.sv]
// Input channel carrying one control point per word.
// Depends on gli_pkg.
interface gli_point_if import gli_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t point_value;

  modport source (output valid, output point_value, input ready);
  modport sink   (input valid, input point_value, output ready);
endinterface

[hdl/gli_entry_if.sv]
// Output channel carrying one lookup table entry per word.
// Depends on gli_pkg.
interface gli_entry_if import gli_pkg::*;;
  logic    valid;
  logic    ready;
  index_t  entry_index;
  sample_t entry_value;
  logic    run_last;

  modport source (output valid, output entry_index, output entry_value, output run_last,
                  input ready);
  modport sink   (input valid, input entry_index, input entry_value, input run_last,
                  output ready);
endinterface

[hdl/gamma_lut_segment_interpolator.sv]
// Gamma table expander: turns control points into interpolated table entries.
// Depends on gli_pkg, gli_point_if and gli_entry_if.
//
//   channel  direction  word contents
//   point    in         point_value
//   entry    out        entry_index, entry_value, run_last
//
// The first point of a curve produces no word.
// Every later point is accepted, then set up, then divided by the single restoring
// divider that splits the slope, then emits one entry per cycle of its segment
// while the entry channel is not stalled.
// Synchronous reset clears the point history and the sequencer.
// A stalled entry word holds the sequencer; a new point is taken once the
// final word of the previous one sits in the output register.
module gamma_lut_segment_interpolator import gli_pkg::*; (
  input logic         clk,
  input logic         rst,
  gli_point_if.sink   point,
  gli_entry_if.source entry
);

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_DIVIDE, ST_EMIT} state_t;

  state_t            state;
  sample_t           previous_point;
  logic [CNT_W-1:0]  point_counter;
  logic [CNT_W-1:0]  seg;
  sample_t           y0;
  sample_t           dy_mag;
  logic              dy_neg;
  logic [XW-1:0]     x;
  logic [XW-1:0]     xend;
  logic [XW-1:0]     dx;
  logic [XW-1:0]     div_rem;
  sample_t           div_num;
  logic [DIV_CW-1:0] div_cnt;
  sample_t           q;
  logic [XW-1:0]     r;
  logic              ev;
  index_t            e_index;
  sample_t           e_value;
  logic              e_last;

  logic [XW-1:0]       x0_c;
  logic [XW-1:0]       x1_c;
  logic                final_c;
  logic [XW:0]         div_sh;
  logic                div_ge;
  logic [XW:0]         r_sum;
  logic                r_wrap;
  logic signed [SAMPLE_WIDTH+1:0] val_s;
  sample_t             val_c;
  logic                load;

  assign point.ready       = (state == ST_IDLE);
  assign entry.valid       = ev;
  assign entry.entry_index = e_index;
  assign entry.entry_value = e_value;
  assign entry.run_last    = e_last;

  always_comb begin
    x0_c    = seg_start(seg);
    x1_c    = seg_start(seg + CNT_W'(1));
    final_c = (seg == CNT_W'(SEGMENT_COUNT - 1));
    div_sh  = {div_rem, div_num[SAMPLE_WIDTH-1]};
    div_ge  = (div_sh >= {1'b0, dx});
    r_sum   = {1'b0, r} + {1'b0, div_rem};
    r_wrap  = (r_sum >= {1'b0, dx});
    if (dy_neg) begin
      val_s = $signed({2'b00, y0}) - $signed({2'b00, q});
    end else begin
      val_s = $signed({2'b00, y0}) + $signed({2'b00, q});
    end
    if (val_s < 0) begin
      val_c = '0;
    end else if (val_s > $signed({2'b00, {SAMPLE_WIDTH{1'b1}}})) begin
      val_c = '1;
    end else begin
      val_c = val_s[SAMPLE_WIDTH-1:0];
    end
    load = (state == ST_EMIT) && (x != xend) && (!ev || entry.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      previous_point <= '0;
      point_counter  <= '0;
      ev             <= 1'b0;
    end else begin
      if (load) begin
        ev <= 1'b1;
      end else if (entry.ready) begin
        ev <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (point.valid) begin
            previous_point <= point.point_value;
            point_counter  <= (point_counter == CNT_W'(SEGMENT_COUNT)) ? '0
                              : point_counter + CNT_W'(1);
            y0     <= previous_point;
            dy_neg <= (point.point_value < previous_point);
            dy_mag <= (point.point_value < previous_point) ?
                      previous_point - point.point_value : point.point_value - previous_point;
            seg    <= point_counter - CNT_W'(1);
            if (point_counter != '0) begin
              state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          x       <= x0_c;
          xend    <= final_c ? x1_c + XW'(1) : x1_c;
          dx      <= x1_c - x0_c;
          div_num <= dy_mag;
          div_rem <= '0;
          div_cnt <= DIV_CW'(SAMPLE_WIDTH);
          q       <= '0;
          r       <= '0;
          state   <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          div_rem <= div_ge ? XW'(div_sh - {1'b0, dx}) : XW'(div_sh);
          div_num <= {div_num[SAMPLE_WIDTH-2:0], div_ge};
          div_cnt <= div_cnt - DIV_CW'(1);
          if (div_cnt == DIV_CW'(1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (x == xend) begin
            state <= ST_IDLE;
          end else if (load) begin
            e_index <= x[IDX_W-1:0];
            e_value <= val_c;
            e_last  <= (x + XW'(1) == xend);
            x       <= x + XW'(1);
            q       <= q + div_num + SAMPLE_WIDTH'(r_wrap);
            r       <= r_wrap ? XW'(r_sum - {1'b0, dx}) : XW'(r_sum);
            if (x + XW'(1) == xend) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The running quotient never passes the slope magnitude while entries remain.
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && x != xend) |-> (q <= dy_mag))
    else $error("interpolation quotient exceeds slope");

  // The running remainder stays below the segment width.
  a_r_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && dx != '0) |-> (r < dx))
    else $error("interpolation remainder out of range");

  // A waiting entry word stays valid and unchanged until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (ev && !entry.ready) |=> (ev && $stable({e_index, e_value, e_last})))
    else $error("waiting entry word changed");

  // The point counter wraps at the end of a curve.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    point_counter <= CNT_W'(SEGMENT_COUNT))
    else $error("point counter out of range");

  // A first point of a curve never starts the sequencer.
  a_first_idle: assert property (@(posedge clk) disable iff (rst)
    (point.valid && point.ready && point_counter == '0) |=> (state == ST_IDLE))
    else $error("first point started a segment");

endmodule
